// ----- sv/c8core_pkg.sv -----
`default_nettype none

package c8core_pkg;

   localparam int unsigned MEMORY_BYTES  = 4096;
   localparam int unsigned SCREEN_WIDTH  = 64;
   localparam int unsigned SCREEN_HEIGHT = 32;
   localparam int unsigned STACK_DEPTH   = 16;
   localparam int unsigned FONT_BYTES    = 80;

   localparam logic [11:0] PC_RESET = 12'h200;

   // Request operation codes.
   localparam logic [1:0] OP_EXEC  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;
   localparam logic [1:0] OP_PIXEL = 2'd3;

   // Instruction groups (top nibble).
   localparam logic [3:0] GRP_SYS   = 4'h0;
   localparam logic [3:0] GRP_JP    = 4'h1;
   localparam logic [3:0] GRP_CALL  = 4'h2;
   localparam logic [3:0] GRP_SE_NN = 4'h3;
   localparam logic [3:0] GRP_SN_NN = 4'h4;
   localparam logic [3:0] GRP_SE_V  = 4'h5;
   localparam logic [3:0] GRP_LD_NN = 4'h6;
   localparam logic [3:0] GRP_ADD   = 4'h7;
   localparam logic [3:0] GRP_ALU   = 4'h8;
   localparam logic [3:0] GRP_SN_V  = 4'h9;
   localparam logic [3:0] GRP_LD_I  = 4'hA;
   localparam logic [3:0] GRP_JP_V0 = 4'hB;
   localparam logic [3:0] GRP_RND   = 4'hC;
   localparam logic [3:0] GRP_DRW   = 4'hD;
   localparam logic [3:0] GRP_KEY   = 4'hE;
   localparam logic [3:0] GRP_MISC  = 4'hF;

   localparam logic [15:0] INS_CLS = 16'h00E0;
   localparam logic [15:0] INS_RET = 16'h00EE;

   // ALU low nibble codes.
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] KEY_SKP  = 8'h9E;
   localparam logic [7:0] KEY_SKNP = 8'hA1;

   localparam logic [7:0] MISC_GET_DT = 8'h07;
   localparam logic [7:0] MISC_WAIT   = 8'h0A;
   localparam logic [7:0] MISC_SET_DT = 8'h15;
   localparam logic [7:0] MISC_SET_ST = 8'h18;
   localparam logic [7:0] MISC_ADD_I  = 8'h1E;
   localparam logic [7:0] MISC_FONT   = 8'h29;
   localparam logic [7:0] MISC_BCD    = 8'h33;
   localparam logic [7:0] MISC_STORE  = 8'h55;
   localparam logic [7:0] MISC_LOAD   = 8'h65;

   localparam logic [3:0] FLAG_REG = 4'hF;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef enum logic [14:0] {
      ST_CLEAR   = 15'b000000000000001,
      ST_IDLE    = 15'b000000000000010,
      ST_FETCH   = 15'b000000000000100,
      ST_DECODE  = 15'b000000000001000,
      ST_EXEC    = 15'b000000000010000,
      ST_FLAG    = 15'b000000000100000,
      ST_BCD     = 15'b000000001000000,
      ST_STO_RD  = 15'b000000010000000,
      ST_STO_WR  = 15'b000000100000000,
      ST_LOD_RD  = 15'b000001000000000,
      ST_LOD_WR  = 15'b000010000000000,
      ST_SPR_RD  = 15'b000100000000000,
      ST_SPR_WR  = 15'b001000000000000,
      ST_SPR_END = 15'b010000000000000,
      ST_RESP    = 15'b100000000000000
   } state_type;

endpackage

`default_nettype wire

// ----- sv/chip8_instruction_core_unit.sv -----
`default_nettype none

// CHIP-8 interpreter core. Each request carries one operation: execute the
// instruction at the program counter, apply one timer tick, write one byte
// of the 4 KiB memory, or read one pixel of the 64x32 display. Every request
// returns exactly one response with the program counter and status flags.
// After reset the core runs a clearing pass that loads the hex font into
// bytes 0-79 and zeroes the rest of memory, the V registers and the return
// stack; req_stall stays high during that pass. The core then handles one
// request at a time under a small sequencer around memories with one write
// port and one registered read port. An instruction is fetched, its
// registers read and it is executed; an ALU op that writes VF adds a flag
// write, BCD three memory writes, FX55 and FX65 a read and a write per
// register, and a sprite one memory row read and one display row
// read-modify-write per sprite row. The longest request is a block store
// or load of all sixteen registers. Each response then waits in the output
// registers until it is taken, and the next request is accepted the cycle
// after that.
module chip8_instruction_core_unit
   import c8core_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_keys_down,
   input  wire logic [7:0]  req_random_value,
   input  wire logic [11:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [11:0] rsp_program_counter,
   output      logic        rsp_draw_request,
   output      logic        rsp_beep_request,
   output      logic        rsp_pixel_value,
   output      logic        rsp_bad_opcode,
   output      logic        rsp_waiting_key
);

   // Storage. Main memory, display rows, V registers and the return stack are
   // arrays with one write port and one registered read port.
   logic [7:0]  mem_array  [MEMORY_BYTES];
   logic [63:0] disp_array [SCREEN_HEIGHT];
   logic [7:0]  vreg_array [16];
   logic [11:0] stk_array  [STACK_DEPTH];

   logic [7:0]  mem_rd_ff;
   logic [63:0] disp_rd_ff;
   logic        disp_vld_rd_ff;
   logic [7:0]  vreg_rd_ff;
   logic [11:0] stk_rd_ff;

   // A display row that is not valid reads as all zero. Reset and clear
   // screen drop every valid bit at once.
   logic [31:0] disp_vld_ff, disp_vld_in;

   state_type   state_ff, state_in;
   logic [11:0] clr_ff, clr_in;
   logic [15:0] keys_ff, keys_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [11:0] addr_ff, addr_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [3:0]  sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in;
   logic [7:0]  st_ff, st_in;
   logic [7:0]  ins_hi_ff, ins_hi_in;
   logic [7:0]  ins_lo_ff, ins_lo_in;
   logic [7:0]  vx_ff, vx_in;
   logic [7:0]  vy_ff, vy_in;
   logic        flag_ff, flag_in;
   logic        hit_ff, hit_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  hund_ff, hund_in;
   logic [3:0]  tens_ff, tens_in;
   logic [3:0]  ones_ff, ones_in;
   logic        draw_ff, draw_in;
   logic        beep_ff, beep_in;
   logic        pix_ff, pix_in;
   logic        bad_ff, bad_in;
   logic        wait_ff, wait_in;

   // Memory port controls.
   logic        mem_we;
   logic [11:0] mem_wa, mem_ra;
   logic [7:0]  mem_wd;
   logic        disp_we;
   logic [4:0]  disp_wa, disp_ra;
   logic [63:0] disp_wd;
   logic        vreg_we;
   logic [3:0]  vreg_wa, vreg_ra;
   logic [7:0]  vreg_wd;
   logic        stk_we;
   logic [3:0]  stk_wa;
   logic [11:0] stk_wd;

   // Decode helpers.
   logic        accept;
   logic [15:0] ins;
   logic [3:0]  x_sel, n_sel;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [11:0] pc_next, pc_skip;
   logic [8:0]  add_sum;
   logic        pressed;
   logic [3:0]  key_low;
   logic [7:0]  bcd_rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens_val;
   logic [7:0]  spr_rev;
   logic [63:0] spr_base, spr_mask, row_cur;
   logic [127:0] spr_rot;
   logic [4:0]  spr_row;
   logic [11:0] idx_off;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_program_counter = pc_ff;
   assign rsp_draw_request = draw_ff;
   assign rsp_beep_request = beep_ff;
   assign rsp_pixel_value = pix_ff;
   assign rsp_bad_opcode = bad_ff;
   assign rsp_waiting_key = wait_ff;

   assign ins     = {ins_hi_ff, ins_lo_ff};
   assign x_sel   = ins_hi_ff[3:0];
   assign n_sel   = ins_lo_ff[3:0];
   assign nn      = ins_lo_ff;
   assign nnn     = {ins_hi_ff[3:0], ins_lo_ff};
   assign pc_next = pc_ff + 12'd2;
   assign pc_skip = pc_ff + 12'd4;
   assign add_sum = {1'b0, vx_ff} + {1'b0, vreg_rd_ff};
   assign pressed = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];

   // Memory address for the block transfers and sprite rows: I plus the
   // running offset, wrapped to 12 bits.
   assign idx_off = idx_ff[11:0] + {8'd0, cnt_ff};

   // Lowest pressed key for the wait-for-key instruction.
   always_comb begin
      key_low = 4'd0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) begin
            key_low = 4'(k);
         end
      end
   end

   // BCD digits of VX. Hundreds by compare, tens by reciprocal multiply
   // (exact for values below 100), ones by subtraction.
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_rem = vx_ff - 8'd200;
      end else if (vx_ff >= 8'd100) begin
         bcd_rem = vx_ff - 8'd100;
      end else begin
         bcd_rem = vx_ff;
      end
      tens_prod = 15'(bcd_rem) * 15'd205;
      tens_val  = tens_prod[14:11];
   end

   // Sprite row placement: bit 7 of the sprite byte lands on column VX, and
   // columns wrap around the screen edge.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         spr_rev[b] = mem_rd_ff[7 - b];
      end
      spr_base = {56'd0, spr_rev};
      spr_rot  = {spr_base, spr_base} << vx_ff[5:0];
      spr_mask = spr_rot[127:64];
      row_cur  = disp_vld_rd_ff ? disp_rd_ff : 64'd0;
      spr_row  = vy_ff[4:0] + {1'b0, cnt_ff};
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      keys_in     = keys_ff;
      rnd_in      = rnd_ff;
      addr_in     = addr_ff;
      pc_in       = pc_ff;
      idx_in      = idx_ff;
      sp_in       = sp_ff;
      dt_in       = dt_ff;
      st_in       = st_ff;
      ins_hi_in   = ins_hi_ff;
      ins_lo_in   = ins_lo_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      flag_in     = flag_ff;
      hit_in      = hit_ff;
      cnt_in      = cnt_ff;
      hund_in     = hund_ff;
      tens_in     = tens_ff;
      ones_in     = ones_ff;
      draw_in     = draw_ff;
      beep_in     = beep_ff;
      pix_in      = pix_ff;
      bad_in      = bad_ff;
      wait_in     = wait_ff;
      disp_vld_in = disp_vld_ff;

      mem_we  = 1'b0;
      mem_wa  = idx_off;
      mem_wd  = vreg_rd_ff;
      mem_ra  = idx_off;
      disp_we = 1'b0;
      disp_wa = spr_row;
      disp_wd = row_cur ^ spr_mask;
      disp_ra = spr_row;
      vreg_we = 1'b0;
      vreg_wa = x_sel;
      vreg_wd = 8'd0;
      vreg_ra = cnt_ff;
      stk_we  = 1'b0;
      stk_wa  = sp_ff;
      stk_wd  = pc_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Font into the low bytes, zero elsewhere; the V registers and
            // stack are zeroed alongside.
            mem_we  = 1'b1;
            mem_wa  = clr_ff;
            mem_wd  = (clr_ff < 12'(FONT_BYTES)) ? FONT_ROM[clr_ff[6:0]] : 8'd0;
            vreg_we = 1'b1;
            vreg_wa = clr_ff[3:0];
            stk_we  = 1'b1;
            stk_wa  = clr_ff[3:0];
            stk_wd  = 12'd0;
            clr_in  = clr_ff + 12'd1;
            if (clr_ff == 12'(MEMORY_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            mem_ra  = pc_ff;
            disp_ra = req_address[10:6];
            if (accept) begin
               keys_in = req_keys_down;
               rnd_in  = req_random_value;
               addr_in = req_address;
               draw_in = 1'b0;
               beep_in = 1'b0;
               pix_in  = 1'b0;
               bad_in  = 1'b0;
               wait_in = 1'b0;
               unique case (req_operation)
                  OP_EXEC: begin
                     state_in = ST_FETCH;
                  end
                  OP_TICK: begin
                     if (dt_ff != 8'd0) begin
                        dt_in = dt_ff - 8'd1;
                     end
                     if (st_ff != 8'd0) begin
                        st_in   = st_ff - 8'd1;
                        beep_in = (st_ff == 8'd1);
                     end
                     state_in = ST_RESP;
                  end
                  OP_LOAD: begin
                     mem_we   = 1'b1;
                     mem_wa   = req_address;
                     mem_wd   = req_data_byte;
                     state_in = ST_RESP;
                  end
                  OP_PIXEL: begin
                     state_in = ST_SPR_END;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            // High opcode byte is on the read port; fetch the low byte and
            // read VX.
            ins_hi_in = mem_rd_ff;
            mem_ra    = pc_ff + 12'd1;
            vreg_ra   = mem_rd_ff[3:0];
            state_in  = ST_DECODE;
         end

         ST_DECODE: begin
            ins_lo_in = mem_rd_ff;
            vx_in     = vreg_rd_ff;
            // The jump with offset needs V0 instead of VY.
            vreg_ra   = (ins_hi_ff[7:4] == GRP_JP_V0) ? 4'd0 : mem_rd_ff[7:4];
            state_in  = ST_EXEC;
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            pc_in    = pc_next;
            vy_in    = vreg_rd_ff;
            unique case (ins_hi_ff[7:4])
               GRP_SYS: begin
                  if (ins == INS_CLS) begin
                     disp_vld_in = 32'd0;
                     draw_in     = 1'b1;
                  end else if (ins == INS_RET) begin
                     sp_in = sp_ff - 4'd1;
                     pc_in = stk_rd_ff + 12'd2;
                  end else begin
                     bad_in = 1'b1;
                     pc_in  = pc_ff;
                  end
               end
               GRP_JP: pc_in = nnn;
               GRP_CALL: begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + 4'd1;
                  pc_in  = nnn;
               end
               GRP_SE_NN: pc_in = (vx_ff == nn) ? pc_skip : pc_next;
               GRP_SN_NN: pc_in = (vx_ff != nn) ? pc_skip : pc_next;
               GRP_SE_V:  pc_in = (vx_ff == vreg_rd_ff) ? pc_skip : pc_next;
               GRP_SN_V:  pc_in = (vx_ff != vreg_rd_ff) ? pc_skip : pc_next;
               GRP_LD_NN: begin
                  vreg_we = 1'b1;
                  vreg_wd = nn;
               end
               GRP_ADD: begin
                  vreg_we = 1'b1;
                  vreg_wd = vx_ff + nn;
               end
               GRP_ALU: begin
                  // Result goes to VX now; ops with a flag write VF in the
                  // following cycle, so VF wins when X is F.
                  vreg_we = 1'b1;
                  unique case (n_sel)
                     ALU_MOV: vreg_wd = vreg_rd_ff;
                     ALU_OR:  vreg_wd = vx_ff | vreg_rd_ff;
                     ALU_AND: vreg_wd = vx_ff & vreg_rd_ff;
                     ALU_XOR: vreg_wd = vx_ff ^ vreg_rd_ff;
                     ALU_ADD: begin
                        vreg_wd  = add_sum[7:0];
                        flag_in  = add_sum[8];
                        state_in = ST_FLAG;
                     end
                     ALU_SUB: begin
                        vreg_wd  = vx_ff - vreg_rd_ff;
                        flag_in  = (vx_ff >= vreg_rd_ff);
                        state_in = ST_FLAG;
                     end
                     ALU_SHR: begin
                        vreg_wd  = {1'b0, vx_ff[7:1]};
                        flag_in  = vx_ff[0];
                        state_in = ST_FLAG;
                     end
                     ALU_SUBN: begin
                        vreg_wd  = vreg_rd_ff - vx_ff;
                        flag_in  = (vreg_rd_ff >= vx_ff);
                        state_in = ST_FLAG;
                     end
                     ALU_SHL: begin
                        vreg_wd  = {vx_ff[6:0], 1'b0};
                        flag_in  = vx_ff[7];
                        state_in = ST_FLAG;
                     end
                     default: begin
                        vreg_we = 1'b0;
                        bad_in  = 1'b1;
                        pc_in   = pc_ff;
                     end
                  endcase
               end
               GRP_LD_I:  idx_in = {4'd0, nnn};
               GRP_JP_V0: pc_in = nnn + {4'd0, vreg_rd_ff};
               GRP_RND: begin
                  vreg_we = 1'b1;
                  vreg_wd = rnd_ff & nn;
               end
               GRP_DRW: begin
                  cnt_in = 4'd0;
                  hit_in = 1'b0;
                  state_in = (n_sel == 4'd0) ? ST_SPR_END : ST_SPR_RD;
               end
               GRP_KEY: begin
                  if (nn == KEY_SKP) begin
                     pc_in = pressed ? pc_skip : pc_next;
                  end else if (nn == KEY_SKNP) begin
                     pc_in = pressed ? pc_next : pc_skip;
                  end else begin
                     bad_in = 1'b1;
                     pc_in  = pc_ff;
                  end
               end
               GRP_MISC: begin
                  cnt_in = 4'd0;
                  unique case (nn)
                     MISC_GET_DT: begin
                        vreg_we = 1'b1;
                        vreg_wd = dt_ff;
                     end
                     MISC_WAIT: begin
                        if (keys_ff == 16'd0) begin
                           wait_in = 1'b1;
                           pc_in   = pc_ff;
                        end else begin
                           vreg_we = 1'b1;
                           vreg_wd = {4'd0, key_low};
                        end
                     end
                     MISC_SET_DT: dt_in = vx_ff;
                     MISC_SET_ST: st_in = vx_ff;
                     MISC_ADD_I:  idx_in = idx_ff + {8'd0, vx_ff};
                     MISC_FONT:   idx_in = 16'(vx_ff) * 16'd5;
                     MISC_BCD: begin
                        hund_in  = (vx_ff >= 8'd200) ? 4'd2 :
                                   ((vx_ff >= 8'd100) ? 4'd1 : 4'd0);
                        tens_in  = tens_val;
                        ones_in  = 4'(bcd_rem - 8'(tens_val) * 8'd10);
                        state_in = ST_BCD;
                     end
                     MISC_STORE: state_in = ST_STO_RD;
                     MISC_LOAD:  state_in = ST_LOD_RD;
                     default: begin
                        bad_in = 1'b1;
                        pc_in  = pc_ff;
                     end
                  endcase
               end
               default: begin
                  bad_in = 1'b1;
                  pc_in  = pc_ff;
               end
            endcase
         end

         ST_FLAG: begin
            vreg_we  = 1'b1;
            vreg_wa  = FLAG_REG;
            vreg_wd  = {7'd0, flag_ff};
            state_in = ST_RESP;
         end

         ST_BCD: begin
            mem_we = 1'b1;
            mem_wd = (cnt_ff == 4'd0) ? {4'd0, hund_ff} :
                     ((cnt_ff == 4'd1) ? {4'd0, tens_ff} : {4'd0, ones_ff});
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               state_in = ST_RESP;
            end
         end

         ST_STO_RD: begin
            state_in = ST_STO_WR;
         end

         ST_STO_WR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == x_sel) begin
               idx_in   = idx_ff + {12'd0, x_sel} + 16'd1;
               state_in = ST_RESP;
            end else begin
               state_in = ST_STO_RD;
            end
         end

         ST_LOD_RD: begin
            state_in = ST_LOD_WR;
         end

         ST_LOD_WR: begin
            vreg_we = 1'b1;
            vreg_wa = cnt_ff;
            vreg_wd = mem_rd_ff;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == x_sel) begin
               idx_in   = idx_ff + {12'd0, x_sel} + 16'd1;
               state_in = ST_RESP;
            end else begin
               state_in = ST_LOD_RD;
            end
         end

         ST_SPR_RD: begin
            state_in = ST_SPR_WR;
         end

         ST_SPR_WR: begin
            // XOR the placed sprite row into the display row and note any
            // pixel that was turned off.
            disp_we = 1'b1;
            disp_vld_in[spr_row] = 1'b1;
            hit_in  = hit_ff || ((row_cur & spr_mask) != 64'd0);
            cnt_in  = cnt_ff + 4'd1;
            state_in = ((cnt_ff + 4'd1) == n_sel) ? ST_SPR_END : ST_SPR_RD;
         end

         ST_SPR_END: begin
            // Shared by sprite completion and by a pixel read, whose display
            // row is on the read port now.
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pixel reads and sprite completion share the end state; a separate
   // marker tells them apart.
   logic pix_op_ff, pix_op_in;

   always_comb begin
      pix_op_in = pix_op_ff;
      if (accept) begin
         pix_op_in = (req_operation == OP_PIXEL);
      end
   end

   logic        end_vreg_we;
   logic        end_pix;

   assign end_vreg_we = (state_ff == ST_SPR_END) && !pix_op_ff;
   assign end_pix     = (state_ff == ST_SPR_END) && pix_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= 12'd0;
         pc_ff       <= PC_RESET;
         idx_ff      <= 16'd0;
         sp_ff       <= 4'd0;
         dt_ff       <= 8'd0;
         st_ff       <= 8'd0;
         disp_vld_ff <= 32'd0;
         draw_ff     <= 1'b0;
         beep_ff     <= 1'b0;
         pix_ff      <= 1'b0;
         bad_ff      <= 1'b0;
         wait_ff     <= 1'b0;
         pix_op_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pc_ff       <= pc_in;
         idx_ff      <= idx_in;
         sp_ff       <= sp_in;
         dt_ff       <= dt_in;
         st_ff       <= st_in;
         disp_vld_ff <= disp_vld_in;
         draw_ff <= draw_in || end_vreg_we;
         beep_ff <= beep_in;
         pix_ff  <= end_pix ? (!addr_ff[11] && disp_vld_rd_ff && disp_rd_ff[addr_ff[5:0]])
                            : pix_in;
         bad_ff    <= bad_in;
         wait_ff   <= wait_in;
         pix_op_ff <= pix_op_in;
      end
   end

   always_ff @(posedge clock) begin
      keys_ff   <= keys_in;
      rnd_ff    <= rnd_in;
      addr_ff   <= addr_in;
      ins_hi_ff <= ins_hi_in;
      ins_lo_ff <= ins_lo_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      flag_ff   <= flag_in;
      hit_ff    <= hit_in;
      cnt_ff    <= cnt_in;
      hund_ff   <= hund_in;
      tens_ff   <= tens_in;
      ones_ff   <= ones_in;
   end

   // Main memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem_array[mem_ra];
   end

   // Display rows.
   always_ff @(posedge clock) begin
      if (disp_we) begin
         disp_array[disp_wa] <= disp_wd;
      end
      disp_rd_ff     <= disp_array[disp_ra];
      disp_vld_rd_ff <= disp_vld_ff[disp_ra];
   end

   // V registers; the sprite end writes the collision flag into VF.
   always_ff @(posedge clock) begin
      if (end_vreg_we) begin
         vreg_array[FLAG_REG] <= {7'd0, hit_ff};
      end else if (vreg_we) begin
         vreg_array[vreg_wa] <= vreg_wd;
      end
      vreg_rd_ff <= vreg_array[vreg_ra];
   end

   // Return stack; the read port always shows the entry below the pointer.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_array[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_array[sp_ff - 4'd1];
   end

endmodule

`default_nettype wire
